### hdl/tpoq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpoq_pkg
// Shared types and constants for the three-phase overcurrent qualifier.
// ----------------------------------------------------------------------------
package tpoq_pkg;

  localparam int CUR_W     = 16;
  localparam int LIMIT_W   = 15;
  localparam int COUNT_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [LIMIT_W-1:0] SOFT_LIMIT_RESET  = LIMIT_W'(20480);
  localparam logic [LIMIT_W-1:0] HARD_LIMIT_RESET  = LIMIT_W'(23680);
  localparam logic [COUNT_W-1:0] COUNT_LIMIT_RESET = COUNT_W'(120);
  localparam logic [COUNT_W-1:0] SETTLE_RESET      = COUNT_W'(10000);
  localparam logic [COUNT_W-1:0] COUNT_MAX         = {COUNT_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOFT_LIMIT  = 2'd0,
    CFG_HARD_LIMIT  = 2'd1,
    CFG_COUNT_LIMIT = 2'd2,
    CFG_SETTLE      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] soft_limit;
    logic [LIMIT_W-1:0] hard_limit;
    logic [COUNT_W-1:0] count_limit;
  } cfg_t;

  typedef struct packed {
    logic               load;
    logic [COUNT_W-1:0] value;
  } blank_load_t;

  typedef struct packed {
    logic hw_fault;
    logic sw_fault;
    logic sw_fault_immediate;
    logic over_soft;
    logic blanking;
  } result_t;

endpackage
`default_nettype wire

### hdl/tpoq_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpoq_cfg_regs
// Configuration register file; a settle write stores nothing here and only reloads the blanking counter.
// ----------------------------------------------------------------------------
module tpoq_cfg_regs
  import tpoq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata,
  output cfg_t                      cfg,
  output blank_load_t               blank_load
);

  logic [LIMIT_W-1:0] soft_r, soft_nxt;
  logic [LIMIT_W-1:0] hard_r, hard_nxt;
  logic [COUNT_W-1:0] climit_r, climit_nxt;
  cfg_idx_t           idx;

  assign idx = cfg_idx_t'(cfg_index);

  always_comb begin
    soft_nxt         = soft_r;
    hard_nxt         = hard_r;
    climit_nxt       = climit_r;
    blank_load.load  = 1'b0;
    blank_load.value = cfg_wdata[COUNT_W-1:0];
    if (cfg_we) begin
      unique case (idx)
        CFG_SOFT_LIMIT:  soft_nxt        = cfg_wdata[LIMIT_W-1:0];
        CFG_HARD_LIMIT:  hard_nxt        = cfg_wdata[LIMIT_W-1:0];
        CFG_COUNT_LIMIT: climit_nxt      = cfg_wdata[COUNT_W-1:0];
        CFG_SETTLE:      blank_load.load = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_r   <= SOFT_LIMIT_RESET;
      hard_r   <= HARD_LIMIT_RESET;
      climit_r <= COUNT_LIMIT_RESET;
    end else begin
      soft_r   <= soft_nxt;
      hard_r   <= hard_nxt;
      climit_r <= climit_nxt;
    end
  end

  assign cfg.soft_limit  = soft_r;
  assign cfg.hard_limit  = hard_r;
  assign cfg.count_limit = climit_r;

endmodule
`default_nettype wire

### hdl/tpoq_phase_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpoq_phase_cmp
// Flags when any of three signed phase currents is strictly beyond +-limit.
// ----------------------------------------------------------------------------
module tpoq_phase_cmp
  import tpoq_pkg::*;
(
  input  wire logic signed [CUR_W-1:0]   cur_a,
  input  wire logic signed [CUR_W-1:0]   cur_b,
  input  wire logic signed [CUR_W-1:0]   cur_c,
  input  wire logic        [LIMIT_W-1:0] limit,
  output logic                           beyond
);

  logic [CUR_W-1:0] mag_a, mag_b, mag_c;
  logic [CUR_W-1:0] lim_ext;

  // magnitude of -32768 is 32768, still fits in 16 unsigned bits
  assign mag_a   = cur_a[CUR_W-1] ? (~cur_a + 1'b1) : cur_a;
  assign mag_b   = cur_b[CUR_W-1] ? (~cur_b + 1'b1) : cur_b;
  assign mag_c   = cur_c[CUR_W-1] ? (~cur_c + 1'b1) : cur_c;
  assign lim_ext = {{(CUR_W-LIMIT_W){1'b0}}, limit};

  assign beyond = (mag_a > lim_ext) || (mag_b > lim_ext) || (mag_c > lim_ext);

endmodule
`default_nettype wire

### hdl/tpoq_qualify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpoq_qualify
// Blanking counter, leaky fault counter and fault decision for one tick.
// ----------------------------------------------------------------------------
module tpoq_qualify
  import tpoq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  cfg_t                          cfg,
  input  blank_load_t                   blank_load,
  input  wire logic                     step,
  input  wire logic signed [CUR_W-1:0]  cur_a,
  input  wire logic signed [CUR_W-1:0]  cur_b,
  input  wire logic signed [CUR_W-1:0]  cur_c,
  input  wire logic                     hw_overcurrent,
  output result_t                       res
);

  logic [COUNT_W-1:0] blank_r, blank_nxt, blank_dec;
  logic [COUNT_W-1:0] leak_r, leak_nxt, leak_inc;
  logic               blank, osoft, ohard, counted;

  tpoq_phase_cmp u_soft_cmp (
    .cur_a (cur_a),
    .cur_b (cur_b),
    .cur_c (cur_c),
    .limit (cfg.soft_limit),
    .beyond(osoft)
  );

  tpoq_phase_cmp u_hard_cmp (
    .cur_a (cur_a),
    .cur_b (cur_b),
    .cur_c (cur_c),
    .limit (cfg.hard_limit),
    .beyond(ohard)
  );

  // decrement happens before the checks of the same tick
  assign blank_dec = (blank_r != '0) ? blank_r - 1'b1 : blank_r;
  assign blank     = (blank_dec != '0);
  assign leak_inc  = (leak_r != COUNT_MAX) ? leak_r + 1'b1 : leak_r;
  assign counted   = osoft && !blank && !ohard;

  always_comb begin
    res.hw_fault           = hw_overcurrent && !blank;
    res.over_soft          = osoft;
    res.blanking           = blank;
    res.sw_fault_immediate = osoft && !blank && ohard;
    res.sw_fault           = res.sw_fault_immediate ||
                             (counted && (leak_inc >= cfg.count_limit));
  end

  always_comb begin
    blank_nxt = blank_r;
    leak_nxt  = leak_r;
    if (step) begin
      blank_nxt = blank_dec;
      if (counted) begin
        leak_nxt = leak_inc;
      end else if (!osoft && leak_r != '0) begin
        leak_nxt = leak_r - 1'b1;
      end
    end
    if (blank_load.load) begin
      blank_nxt = blank_load.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r <= SETTLE_RESET;
      leak_r  <= '0;
    end else begin
      blank_r <= blank_nxt;
      leak_r  <= leak_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/three_phase_overcurrent_qualifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_phase_overcurrent_qualifier
// Qualifies phase currents and the comparator flag into hw/sw overcurrent faults.
//
//   port group   direction  handshake           payload
//   in_*         input      in_valid/in_stall   current_a/b/c, hw_overcurrent
//   out_*        output     out_valid/out_stall hw_fault, sw_fault, sw_fault_immediate,
//                                               over_soft, blanking
//   cfg_*        input      cfg_we              cfg_index, cfg_wdata
//
// One item per cycle while out_stall is low; items pass through the input register, then the result register.
// Counters update when an item moves from the input register into the result register.
// A stall on a valid output holds the result register, and a full input register;
// in_stall rises only when the input register is full and cannot drain.
// Synchronous reset loads the limit reset values, blanking count 10000, leak count 0.
// ----------------------------------------------------------------------------
module three_phase_overcurrent_qualifier
  import tpoq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic signed [CUR_W-1:0]  in_current_a,
  input  wire logic signed [CUR_W-1:0]  in_current_b,
  input  wire logic signed [CUR_W-1:0]  in_current_c,
  input  wire logic                     in_hw_overcurrent,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          out_hw_fault,
  output logic                          out_sw_fault,
  output logic                          out_sw_fault_immediate,
  output logic                          out_over_soft,
  output logic                          out_blanking,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [CFG_DAT_W-1:0]     cfg_wdata
);

  cfg_t              cfg;
  blank_load_t       blank_load;
  result_t           res;
  result_t           res_r;

  logic                    s1_valid_r, s1_valid_nxt;
  logic signed [CUR_W-1:0] cur_a_r, cur_b_r, cur_c_r;
  logic                    hw_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    move, accept, step;

  tpoq_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .blank_load(blank_load)
  );

  // result register can take a new transfer when empty or being drained
  assign move     = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !move;
  assign accept   = in_valid && !in_stall;
  assign step     = move && s1_valid_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = move ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_a_r <= in_current_a;
      cur_b_r <= in_current_b;
      cur_c_r <= in_current_c;
      hw_r    <= in_hw_overcurrent;
    end
    if (step) begin
      res_r <= res;
    end
  end

  tpoq_qualify u_qual (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .blank_load    (blank_load),
    .step          (step),
    .cur_a         (cur_a_r),
    .cur_b         (cur_b_r),
    .cur_c         (cur_c_r),
    .hw_overcurrent(hw_r),
    .res           (res)
  );

  assign out_valid              = out_valid_r;
  assign out_hw_fault           = res_r.hw_fault;
  assign out_sw_fault           = res_r.sw_fault;
  assign out_sw_fault_immediate = res_r.sw_fault_immediate;
  assign out_over_soft          = res_r.over_soft;
  assign out_blanking           = res_r.blanking;

endmodule
`default_nettype wire

### hdl/tpoq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpoq_checker
// Port-level checks on the qualifier results, bound to the top level.
// ----------------------------------------------------------------------------
module tpoq_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_hw_fault,
  input wire logic out_sw_fault,
  input wire logic out_sw_fault_immediate,
  input wire logic out_over_soft,
  input wire logic out_blanking
);

  // an immediate fault is always a software fault
  a_imm_is_sw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sw_fault_immediate |-> out_sw_fault)
    else $error("immediate fault without sw_fault");

  // blanking suppresses every fault
  a_blank_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_blanking |-> !out_hw_fault && !out_sw_fault)
    else $error("fault reported while blanking");

  // any software fault needs some phase over the soft limit
  a_sw_needs_soft: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sw_fault |-> out_over_soft)
    else $error("sw fault without over_soft");

  // a stalled result stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped under stall");

endmodule

bind three_phase_overcurrent_qualifier tpoq_checker u_tpoq_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_hw_fault          (out_hw_fault),
  .out_sw_fault          (out_sw_fault),
  .out_sw_fault_immediate(out_sw_fault_immediate),
  .out_over_soft         (out_over_soft),
  .out_blanking          (out_blanking)
);
`default_nettype wire
